FILE: rtl/bsife_pkg.sv
`default_nettype none

package bsife_pkg;

    // Line codes of the framing scheme.
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_FLAG   = 8'h5E;
    localparam logic [7:0] ESC_ESC    = 8'h5D;
    localparam int         SEQ_SHIFT  = 6;
    localparam logic [7:0] ADDR_RESET = 8'h03;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One payload byte as it arrives.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       seq_bit;
    } in_item_t;

    // One byte of the line stream.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_run;
    } out_item_t;

    // Classified work for the back end: everything needed to emit one run.
    typedef struct packed {
        logic       hdr;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
        logic       last;
        logic [7:0] bcc2;
    } job_t;

    // Fill status of the job queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bsife_front.sv
`default_nettype none

module bsife_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bsife_pkg::in_item_t s_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    input  wire bsife_pkg::queue_stat_t q_stat,
    output logic                   push,
    output bsife_pkg::job_t        push_job
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] addr_reg;
    logic [7:0] ctrl;
    logic [7:0] xor_acc;

    // The address register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // An item is taken whenever the queue has room.
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // Classify the item: header needed, control byte and check byte.
    always_comb begin
        ctrl    = 8'(s_item.seq_bit) << bsife_pkg::SEQ_SHIFT;
        xor_acc = (in_frame_reg ? xor_reg : 8'h00) ^ s_item.data_byte;

        push_job.hdr  = !in_frame_reg;
        push_job.addr = addr_reg;
        push_job.ctrl = ctrl;
        push_job.data = s_item.data_byte;
        push_job.last = s_item.last_byte;
        push_job.bcc2 = xor_acc;

        in_frame_next = in_frame_reg;
        xor_next      = xor_reg;
        if (push) begin
            in_frame_next = !s_item.last_byte;
            xor_next      = s_item.last_byte ? 8'h00 : xor_acc;
        end
    end

    // Frame state and the address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            xor_reg      <= 8'h00;
            addr_reg     <= bsife_pkg::ADDR_RESET;
        end else begin
            in_frame_reg <= in_frame_next;
            xor_reg      <= xor_next;
            if (cfg_valid && cfg_ready) begin
                addr_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bsife_queue.sv
`default_nettype none

module bsife_queue #(
    parameter int DEPTH = bsife_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire bsife_pkg::job_t push_job,
    input  wire logic            pop,
    output bsife_pkg::job_t      head_job,
    output bsife_pkg::queue_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsife_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    // Entries hold payload only and need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers wrap at the depth; the count tracks fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bsife_back.sv
`default_nettype none

module bsife_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bsife_pkg::job_t   head_job,
    input  wire bsife_pkg::queue_stat_t q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bsife_pkg::out_item_t   m_item
);

    // Emission phases of one run.
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_H0    = 4'd1;
    localparam logic [3:0] PH_H1    = 4'd2;
    localparam logic [3:0] PH_H2    = 4'd3;
    localparam logic [3:0] PH_H3    = 4'd4;
    localparam logic [3:0] PH_D0    = 4'd5;
    localparam logic [3:0] PH_D1    = 4'd6;
    localparam logic [3:0] PH_B0    = 4'd7;
    localparam logic [3:0] PH_B1    = 4'd8;
    localparam logic [3:0] PH_F     = 4'd9;

    logic [3:0]           phase_reg;
    logic [3:0]           cur_phase, nxt_phase;
    logic                 done;
    logic                 load;
    logic [7:0]           byte_out;
    logic                 m_valid_reg;
    bsife_pkg::out_item_t m_item_reg;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == bsife_pkg::FLAG_BYTE) || (b == bsife_pkg::ESC_BYTE);
    endfunction

    function automatic logic [7:0] stuff_first(input logic [7:0] b);
        return needs_esc(b) ? bsife_pkg::ESC_BYTE : b;
    endfunction

    function automatic logic [7:0] stuff_second(input logic [7:0] b);
        return (b == bsife_pkg::FLAG_BYTE) ? bsife_pkg::ESC_FLAG : bsife_pkg::ESC_ESC;
    endfunction

    // Output register loads when a job waits and it is empty or drained.
    assign load = !q_stat.empty && (!m_valid_reg || m_ready);
    assign pop  = load && done;

    // Select the byte of the current phase and the phase that follows.
    always_comb begin
        cur_phase = phase_reg;
        if (phase_reg == PH_START) begin
            cur_phase = head_job.hdr ? PH_H0 : PH_D0;
        end
        byte_out  = bsife_pkg::FLAG_BYTE;
        nxt_phase = PH_START;
        done      = 1'b0;
        unique case (cur_phase)
            PH_H0: begin
                byte_out  = bsife_pkg::FLAG_BYTE;
                nxt_phase = PH_H1;
            end
            PH_H1: begin
                byte_out  = head_job.addr;
                nxt_phase = PH_H2;
            end
            PH_H2: begin
                byte_out  = head_job.ctrl;
                nxt_phase = PH_H3;
            end
            PH_H3: begin
                byte_out  = head_job.addr ^ head_job.ctrl;
                nxt_phase = PH_D0;
            end
            PH_D0: begin
                byte_out = stuff_first(head_job.data);
                if (needs_esc(head_job.data)) begin
                    nxt_phase = PH_D1;
                end else if (head_job.last) begin
                    nxt_phase = PH_B0;
                end else begin
                    done = 1'b1;
                end
            end
            PH_D1: begin
                byte_out = stuff_second(head_job.data);
                if (head_job.last) begin
                    nxt_phase = PH_B0;
                end else begin
                    done = 1'b1;
                end
            end
            PH_B0: begin
                byte_out  = stuff_first(head_job.bcc2);
                nxt_phase = needs_esc(head_job.bcc2) ? PH_B1 : PH_F;
            end
            PH_B1: begin
                byte_out  = stuff_second(head_job.bcc2);
                nxt_phase = PH_F;
            end
            PH_F: begin
                byte_out = bsife_pkg::FLAG_BYTE;
                done     = 1'b1;
            end
            default: begin
                byte_out = bsife_pkg::FLAG_BYTE;
                done     = 1'b1;
            end
        endcase
    end

    // Sequencer state and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                phase_reg   <= done ? PH_START : nxt_phase;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg.line_byte   <= byte_out;
            m_item_reg.last_of_run <= done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

FILE: rtl/byte_stuffed_info_frame_encoder.sv
`default_nettype none

// Channel   Ports                          Carries
// input     s_valid  s_ready  s_item       one payload byte, last mark, sequence bit
// output    m_valid  m_ready  m_item       one line byte, end-of-run mark
// config    cfg_valid cfg_ready cfg_data   address byte (always ready)
//
// The back end emits one line byte per cycle while jobs wait and the output is not
// stalled; an item causes 1 or 2 line bytes mid-frame, up to 9 for a single-byte frame.
// The front end accepts one item per cycle while the job queue has room.
// Reset is synchronous, active low; it closes any open frame and sets the address to 3.
// A stall on the output holds the output register; the queue then fills and stalls input.

module byte_stuffed_info_frame_encoder #(
    parameter int QUEUE_DEPTH = bsife_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bsife_pkg::in_item_t s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bsife_pkg::out_item_t     m_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    bsife_pkg::job_t        push_job, head_job;
    bsife_pkg::queue_stat_t q_stat;
    logic                   push, pop;

    // Front end: accepts and classifies items.
    bsife_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue between the two ends.
    bsife_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Back end: serializes each job onto the line.
    bsife_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // The queue never takes a job while full.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    // A byte that does not end its run still has its job in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last_of_run) |-> !q_stat.empty)
        else $error("job retired before its run was complete");

    // Retiring a job always presents the final byte of its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_item.last_of_run))
        else $error("job retired without an end-of-run byte");

endmodule

`default_nettype wire

FILE: verif/tb_byte_stuffed_info_frame_encoder.sv
`timescale 1ns / 1ps

module tb_byte_stuffed_info_frame_encoder;

    // Cycles to let the block settle once nothing more is expected.
    localparam int SETTLE_CYCLES = 30;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    bsife_pkg::in_item_t  s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    bsife_pkg::out_item_t m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_data = 8'h00;

    // Items waiting to be sent, and line bytes still owed by the block.
    bsife_pkg::in_item_t  pending_q[$];
    bsife_pkg::out_item_t line_exp_q[$];

    // Encoder state as the testbench sees it.
    logic [7:0] addr_model = bsife_pkg::ADDR_RESET;
    logic       frame_open = 1'b0;
    logic [7:0] bcc_acc = 8'h00;
    logic [7:0] run_q[$];

    // Stimulus shaping.
    logic       pause_tx = 1'b0;
    logic       calm = 1'b0;
    int         tx_gap = 0;
    int         rx_stall = 0;
    int         err_count = 0;
    int         bytes_checked = 0;

    byte_stuffed_info_frame_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic log_mismatch(string msg);
        $display("MISMATCH at line byte %0d: %s", bytes_checked, msg);
        err_count++;
    endtask

    // Append one byte to the current run, escaping flag and escape codes.
    function automatic void run_stuffed(logic [7:0] b);
        if (b == bsife_pkg::FLAG_BYTE) begin
            run_q.push_back(bsife_pkg::ESC_BYTE);
            run_q.push_back(bsife_pkg::ESC_FLAG);
        end else if (b == bsife_pkg::ESC_BYTE) begin
            run_q.push_back(bsife_pkg::ESC_BYTE);
            run_q.push_back(bsife_pkg::ESC_ESC);
        end else begin
            run_q.push_back(b);
        end
    endfunction

    // Work out the line bytes that one accepted item causes.
    function automatic void encode_item(bsife_pkg::in_item_t it);
        logic [7:0]           ctrl;
        bsife_pkg::out_item_t o;
        run_q.delete();
        if (!frame_open) begin
            ctrl = 8'(it.seq_bit) << bsife_pkg::SEQ_SHIFT;
            run_q.push_back(bsife_pkg::FLAG_BYTE);
            run_q.push_back(addr_model);
            run_q.push_back(ctrl);
            run_q.push_back(addr_model ^ ctrl);
            bcc_acc = 8'h00;
            frame_open = 1'b1;
        end
        run_stuffed(it.data_byte);
        bcc_acc = bcc_acc ^ it.data_byte;
        if (it.last_byte) begin
            run_stuffed(bcc_acc);
            run_q.push_back(bsife_pkg::FLAG_BYTE);
            frame_open = 1'b0;
            bcc_acc = 8'h00;
        end
        foreach (run_q[i]) begin
            o.line_byte = run_q[i];
            o.last_of_run = (i == run_q.size() - 1);
            line_exp_q.push_back(o);
        end
    endfunction

    // Input driver: predicts on each accepted item, then offers the next one.
    always @(posedge aclk) begin
        logic                nxt_valid;
        bsife_pkg::in_item_t nxt_item;
        nxt_valid = s_valid;
        nxt_item = s_item;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                encode_item(s_item);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!pause_tx && pending_q.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        tx_gap = $urandom_range(0, 3);
                    end else begin
                        nxt_item = pending_q.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
        end
        s_valid <= nxt_valid;
        s_item <= nxt_item;
    end

    // Output monitor: checks each accepted line byte and applies random stalls.
    always @(posedge aclk) begin
        logic                 nxt_ready;
        bsife_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_exp_q.size() == 0) begin
                log_mismatch($sformatf("unexpected byte %02h", m_item.line_byte));
            end else begin
                want = line_exp_q.pop_front();
                if (m_item.line_byte !== want.line_byte)
                    log_mismatch($sformatf("line_byte %02h, expected %02h",
                                           m_item.line_byte, want.line_byte));
                if (m_item.last_of_run !== want.last_of_run)
                    log_mismatch($sformatf("last_of_run %0b, expected %0b",
                                           m_item.last_of_run, want.last_of_run));
            end
            bytes_checked++;
        end
        if (rx_stall > 0) begin
            rx_stall--;
            nxt_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(0, 3);
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        m_ready <= nxt_ready;
    end

    task automatic add_item(logic [7:0] d, logic l, logic s);
        bsife_pkg::in_item_t it;
        it.data_byte = d;
        it.last_byte = l;
        it.seq_bit = s;
        pending_q.push_back(it);
    endtask

    // A random payload byte, often one of the codes that need escaping.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return bsife_pkg::FLAG_BYTE;
            1: return bsife_pkg::ESC_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // Wait until every item is sent and every line byte has come back.
    task automatic drain();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || line_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the address register; only called while the block is idle.
    task automatic write_address(logic [7:0] a);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= a;
        do @(posedge aclk);
        while (!cfg_ready);
        addr_model = a;
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Queue complete random frames until about n items are waiting.
    task automatic add_frames(int n);
        int len;
        int cnt;
        cnt = 0;
        while (cnt < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                              : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
                add_item(pick_byte(), i == len - 1, 1'($urandom));
            cnt += len;
        end
    endtask

    // Main sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-byte frames at the data extremes and both sequence values.
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1);
        add_item(bsife_pkg::FLAG_BYTE, 1'b1, 1'b0);
        add_item(bsife_pkg::ESC_BYTE, 1'b1, 1'b1);
        // Escaping codes in a longer frame, with the sequence bit toggling mid-frame.
        add_item(bsife_pkg::FLAG_BYTE, 1'b0, 1'b1);
        add_item(bsife_pkg::ESC_BYTE, 1'b0, 1'b0);
        add_item(bsife_pkg::ESC_FLAG, 1'b0, 1'b1);
        add_item(bsife_pkg::ESC_ESC, 1'b1, 1'b0);
        // Check bytes that must themselves be escaped.
        add_item(8'h01, 1'b0, 1'b0);
        add_item(8'h7F, 1'b1, 1'b1);
        add_item(8'h01, 1'b0, 1'b1);
        add_item(8'h7C, 1'b1, 1'b0);
        // Leave a frame open across an address change.
        add_item(8'hAA, 1'b0, 1'b1);
        drain();
        write_address(8'h00);
        add_item(8'h55, 1'b1, 1'b0);
        add_item(8'h12, 1'b1, 1'b1);
        drain();
        write_address(8'hFF);
        add_item(8'h80, 1'b1, 1'b0);
        drain();
        write_address(bsife_pkg::FLAG_BYTE);
        add_item(bsife_pkg::FLAG_BYTE, 1'b1, 1'b1);
        drain();
        write_address(bsife_pkg::ESC_BYTE);
        add_item(bsife_pkg::ESC_BYTE, 1'b1, 1'b0);
        drain();

        // Random frames under several addresses; the last phase runs without idling.
        for (int p = 0; p < 4; p++) begin
            write_address(p == 1 ? bsife_pkg::ADDR_RESET : 8'($urandom));
            if (p == 3)
                calm = 1'b1;
            add_frames(75);
            if (p == 1) begin
                // Hold the sender midway until the block has caught up.
                do @(negedge aclk);
                while (pending_q.size() > 35);
                pause_tx = 1'b1;
                do @(negedge aclk);
                while (s_valid || line_exp_q.size() != 0);
                pause_tx = 1'b0;
            end
            drain();
        end

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
